FILE: design/bab_pkg.sv
// Shared types and constants for the box affine bounds block.
// Used by box_affine_bounds, bab_row and bab_checker; depends on nothing.
package bab_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int COORD_W       = 32;
	localparam int PROD_W        = 2 * COORD_W;
	localparam int REG_W         = 64;
	localparam int NUM_REGS      = 6;
	localparam int NUM_AXES      = 3;
	localparam int CFG_IDX_W     = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROW_X_AB = 3'd0,
		REG_ROW_X_CD = 3'd1,
		REG_ROW_Y_AB = 3'd2,
		REG_ROW_Y_CD = 3'd3,
		REG_ROW_Z_AB = 3'd4,
		REG_ROW_Z_CD = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] box_min_x;
		logic signed [COORD_W-1:0] box_min_y;
		logic signed [COORD_W-1:0] box_min_z;
		logic signed [COORD_W-1:0] box_max_x;
		logic signed [COORD_W-1:0] box_max_y;
		logic signed [COORD_W-1:0] box_max_z;
	} box_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] out_min_x;
		logic signed [COORD_W-1:0] out_min_y;
		logic signed [COORD_W-1:0] out_min_z;
		logic signed [COORD_W-1:0] out_max_x;
		logic signed [COORD_W-1:0] out_max_y;
		logic signed [COORD_W-1:0] out_max_z;
		logic                      saturated;
	} bounds_t;

	// load enables of the three datapath stages inside a row
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
	} pipe_en_t;

endpackage

FILE: design/bab_row.sv
// One output row of the transform: products, per-term min/max, row sums.
// Depends on bab_pkg.
module bab_row #(
	parameter int FRAC_BITS = bab_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  bab_pkg::pipe_en_t                   en,
	input  logic signed [bab_pkg::COORD_W-1:0]  coef_a,
	input  logic signed [bab_pkg::COORD_W-1:0]  coef_b,
	input  logic signed [bab_pkg::COORD_W-1:0]  coef_c,
	input  logic signed [bab_pkg::COORD_W-1:0]  coef_t,
	input  bab_pkg::box_t                       box,
	output logic signed [bab_pkg::PROD_W-FRAC_BITS+1:0] sum_min,
	output logic signed [bab_pkg::PROD_W-FRAC_BITS+1:0] sum_max
);

	localparam int TERM_W = bab_pkg::PROD_W - FRAC_BITS;
	localparam int SUM_W  = TERM_W + 2;

	logic signed [bab_pkg::COORD_W-1:0] coef [bab_pkg::NUM_AXES];
	logic signed [bab_pkg::COORD_W-1:0] lo   [bab_pkg::NUM_AXES];
	logic signed [bab_pkg::COORD_W-1:0] hi   [bab_pkg::NUM_AXES];

	logic signed [bab_pkg::PROD_W-1:0]  prod_lo_s1 [bab_pkg::NUM_AXES];
	logic signed [bab_pkg::PROD_W-1:0]  prod_hi_s1 [bab_pkg::NUM_AXES];
	logic signed [bab_pkg::COORD_W-1:0] t_s1;
	logic signed [TERM_W-1:0]           mn_s2 [bab_pkg::NUM_AXES];
	logic signed [TERM_W-1:0]           mx_s2 [bab_pkg::NUM_AXES];
	logic signed [bab_pkg::COORD_W-1:0] t_s2;
	logic signed [SUM_W-1:0]            sum_min_s3;
	logic signed [SUM_W-1:0]            sum_max_s3;

	assign coef[0] = coef_a;
	assign coef[1] = coef_b;
	assign coef[2] = coef_c;
	assign lo[0]   = box.box_min_x;
	assign lo[1]   = box.box_min_y;
	assign lo[2]   = box.box_min_z;
	assign hi[0]   = box.box_max_x;
	assign hi[1]   = box.box_max_y;
	assign hi[2]   = box.box_max_z;

	// full signed products of both corners
	always_ff @(posedge clk) begin
		if (en.s1) begin
			for (int k = 0; k < bab_pkg::NUM_AXES; k++) begin
				prod_lo_s1[k] <= bab_pkg::PROD_W'(coef[k]) * bab_pkg::PROD_W'(lo[k]);
				prod_hi_s1[k] <= bab_pkg::PROD_W'(coef[k]) * bab_pkg::PROD_W'(hi[k]);
			end
			t_s1 <= coef_t;
		end
	end

	// floor shift, then keep the smaller and larger term
	always_ff @(posedge clk) begin
		if (en.s2) begin
			for (int k = 0; k < bab_pkg::NUM_AXES; k++) begin
				if (TERM_W'(prod_lo_s1[k] >>> FRAC_BITS) < TERM_W'(prod_hi_s1[k] >>> FRAC_BITS)) begin
					mn_s2[k] <= TERM_W'(prod_lo_s1[k] >>> FRAC_BITS);
					mx_s2[k] <= TERM_W'(prod_hi_s1[k] >>> FRAC_BITS);
				end else begin
					mn_s2[k] <= TERM_W'(prod_hi_s1[k] >>> FRAC_BITS);
					mx_s2[k] <= TERM_W'(prod_lo_s1[k] >>> FRAC_BITS);
				end
			end
			t_s2 <= t_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			sum_min_s3 <= SUM_W'(t_s2) + SUM_W'(mn_s2[0]) + SUM_W'(mn_s2[1]) + SUM_W'(mn_s2[2]);
			sum_max_s3 <= SUM_W'(t_s2) + SUM_W'(mx_s2[0]) + SUM_W'(mx_s2[1]) + SUM_W'(mx_s2[2]);
		end
	end

	assign sum_min = sum_min_s3;
	assign sum_max = sum_max_s3;

endmodule

FILE: design/box_affine_bounds.sv
// Top level of the box affine bounds block: register file, pipeline
// control, saturation and output register. Depends on bab_pkg and bab_row.
//
// Usage:
//   Input channel (box_valid / box_stall / box) takes one axis-aligned box,
//   lower and upper corner in signed fixed point with FRAC_BITS fraction
//   bits. Output channel (bounds_valid / bounds_stall / bounds) returns the
//   axis-aligned bounds of that box under the 3x4 affine transform, each
//   bound clamped to 32 bits, with saturated set when any bound clamped.
//   Configuration channel (cfg_valid / cfg_ready / cfg_addr / cfg_data)
//   writes the six 64-bit coefficient registers; cfg_ready is always high
//   and an index past the last register is dropped. Write only while no
//   request is in flight.
//   Pipeline: four register stages (multiply, min/max select, row sum,
//   clamp into the output register), which an accepted box passes in
//   that order before bounds_valid rises with its result.
//   Throughput: one box per cycle while the output is not stalled; the 18
//   parallel 32x32 multipliers of the first stage set the per-cycle work.
//   Reset: all stages empty, registers load the identity transform with
//   zero translation.
//   Stall: a stalled result holds in the output register; earlier stages
//   keep advancing into empty slots and box_stall rises only once every
//   stage is full.
module box_affine_bounds #(
	parameter int FRAC_BITS = bab_pkg::FRAC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            box_valid,
	output logic                            box_stall,
	input  bab_pkg::box_t                   box,
	output logic                            bounds_valid,
	input  logic                            bounds_stall,
	output bab_pkg::bounds_t                bounds,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [bab_pkg::CFG_IDX_W-1:0]   cfg_addr,
	input  logic [bab_pkg::REG_W-1:0]       cfg_data
);

	localparam int SUM_W = bab_pkg::PROD_W - FRAC_BITS + 2;
	localparam logic [bab_pkg::REG_W-1:0] ONE_LO = bab_pkg::REG_W'(1) << FRAC_BITS;
	localparam logic [bab_pkg::REG_W-1:0] ONE_HI =
		bab_pkg::REG_W'(1) << (FRAC_BITS + bab_pkg::COORD_W);

	logic [bab_pkg::REG_W-1:0] regs_q [bab_pkg::NUM_REGS];

	bab_pkg::pipe_en_t en;
	logic              en_out;
	logic              v_s1, v_s2, v_s3;
	logic              bounds_valid_q;
	bab_pkg::bounds_t  bounds_q;

	logic signed [SUM_W-1:0] sum_min [bab_pkg::NUM_AXES];
	logic signed [SUM_W-1:0] sum_max [bab_pkg::NUM_AXES];
	logic signed [bab_pkg::COORD_W-1:0] cl_min [bab_pkg::NUM_AXES];
	logic signed [bab_pkg::COORD_W-1:0] cl_max [bab_pkg::NUM_AXES];
	logic                    sat_any;

	// Configuration registers: always ready, unknown indexes are dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q[0] <= ONE_LO;
			regs_q[1] <= '0;
			regs_q[2] <= ONE_HI;
			regs_q[3] <= '0;
			regs_q[4] <= '0;
			regs_q[5] <= ONE_LO;
		end else if (cfg_valid && cfg_ready) begin
			case (bab_pkg::cfg_reg_t'(cfg_addr))
				bab_pkg::REG_ROW_X_AB: regs_q[0] <= cfg_data;
				bab_pkg::REG_ROW_X_CD: regs_q[1] <= cfg_data;
				bab_pkg::REG_ROW_Y_AB: regs_q[2] <= cfg_data;
				bab_pkg::REG_ROW_Y_CD: regs_q[3] <= cfg_data;
				bab_pkg::REG_ROW_Z_AB: regs_q[4] <= cfg_data;
				bab_pkg::REG_ROW_Z_CD: regs_q[5] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Stage enables: a stage loads when it is empty or its successor loads,
	// so bubbles squeeze out behind a stalled output.
	assign en_out    = !bounds_valid_q || !bounds_stall;
	assign en.s3     = !v_s3 || en_out;
	assign en.s2     = !v_s2 || en.s3;
	assign en.s1     = !v_s1 || en.s2;
	assign box_stall = !en.s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1           <= 1'b0;
			v_s2           <= 1'b0;
			v_s3           <= 1'b0;
			bounds_valid_q <= 1'b0;
		end else begin
			if (en.s1) v_s1 <= box_valid;
			if (en.s2) v_s2 <= v_s1;
			if (en.s3) v_s3 <= v_s2;
			if (en_out) bounds_valid_q <= v_s3;
		end
	end

	// One row unit per output axis; coefficient a, b in the ab register,
	// c and translation in the cd register, low half first.
	for (genvar r = 0; r < bab_pkg::NUM_AXES; r++) begin : g_row
		bab_row #(
			.FRAC_BITS(FRAC_BITS)
		) u_row (
			.clk     (clk),
			.en      (en),
			.coef_a  (regs_q[2*r][bab_pkg::COORD_W-1:0]),
			.coef_b  (regs_q[2*r][bab_pkg::REG_W-1:bab_pkg::COORD_W]),
			.coef_c  (regs_q[2*r+1][bab_pkg::COORD_W-1:0]),
			.coef_t  (regs_q[2*r+1][bab_pkg::REG_W-1:bab_pkg::COORD_W]),
			.box     (box),
			.sum_min (sum_min[r]),
			.sum_max (sum_max[r])
		);
	end

	function automatic logic ovf(input logic signed [SUM_W-1:0] v);
		logic [SUM_W-bab_pkg::COORD_W:0] top;
		top = v[SUM_W-1:bab_pkg::COORD_W-1];
		return !((&top) || !(|top));
	endfunction

	function automatic logic signed [bab_pkg::COORD_W-1:0] clamp(
		input logic signed [SUM_W-1:0] v
	);
		logic signed [bab_pkg::COORD_W-1:0] r;
		if (!ovf(v)) begin
			r = v[bab_pkg::COORD_W-1:0];
		end else if (v[SUM_W-1]) begin
			r = {1'b1, {(bab_pkg::COORD_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(bab_pkg::COORD_W-1){1'b1}}};
		end
		return r;
	endfunction

	always_comb begin
		sat_any = 1'b0;
		for (int k = 0; k < bab_pkg::NUM_AXES; k++) begin
			cl_min[k] = clamp(sum_min[k]);
			cl_max[k] = clamp(sum_max[k]);
			sat_any   = sat_any | ovf(sum_min[k]) | ovf(sum_max[k]);
		end
	end

	// Output register: hold while the receiver stalls.
	always_ff @(posedge clk) begin
		if (en_out) begin
			bounds_q.out_min_x <= cl_min[0];
			bounds_q.out_min_y <= cl_min[1];
			bounds_q.out_min_z <= cl_min[2];
			bounds_q.out_max_x <= cl_max[0];
			bounds_q.out_max_y <= cl_max[1];
			bounds_q.out_max_z <= cl_max[2];
			bounds_q.saturated <= sat_any;
		end
	end

	assign bounds_valid = bounds_valid_q;
	assign bounds       = bounds_q;

endmodule

FILE: design/bab_checker.sv
// Port-level checks for box_affine_bounds, attached by bind.
// Depends on bab_pkg.
module bab_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          box_valid,
	input logic                          box_stall,
	input logic                          bounds_valid,
	input logic                          bounds_stall,
	input bab_pkg::bounds_t              bounds,
	input logic                          cfg_ready
);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		bounds_valid && bounds_stall |=> bounds_valid && $stable(bounds))
		else $error("stalled result changed");

	// input backs up only behind a stalled, full output
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		box_stall |-> bounds_valid && bounds_stall)
		else $error("input stalled without output stall");

	// an accepted request reaches the output when the output drains
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(box_valid && !box_stall) ##1 !bounds_stall ##1 !bounds_stall ##1 !bounds_stall
		|=> bounds_valid)
		else $error("request did not arrive after four cycles");

	// lower bound never exceeds upper bound, clamped or not
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		bounds_valid |-> ($signed(bounds.out_min_x) <= $signed(bounds.out_max_x)) &&
			($signed(bounds.out_min_y) <= $signed(bounds.out_max_y)) &&
			($signed(bounds.out_min_z) <= $signed(bounds.out_max_z)))
		else $error("lower bound above upper bound");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("configuration channel not ready");

endmodule

bind box_affine_bounds bab_checker u_bab_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.box_valid    (box_valid),
	.box_stall    (box_stall),
	.bounds_valid (bounds_valid),
	.bounds_stall (bounds_stall),
	.bounds       (bounds),
	.cfg_ready    (cfg_ready)
);

FILE: test/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for box_affine_bounds: predicts each transformed box's bounds
// in fixed point and checks every result, field by field, in order of the requests.
// Depends on bab_pkg and the box_affine_bounds RTL only.
module tb;

	localparam int FRAC       = bab_pkg::FRAC_BITS_DEF;
	localparam int WATCHDOG   = 4000;   // cycles with no handshake on any channel
	localparam int TAIL_WAIT  = 12;     // wait past the last result for any stray one
	localparam int LONG_HOLD  = 300;    // receiver hold-off in the backpressure test
	localparam int MAX_PRINTS = 40;

	localparam logic [31:0] Q_ONE = 32'd1 << FRAC;
	localparam logic [31:0] Q_MAX = 32'h7fff_ffff;
	localparam logic [31:0] Q_MIN = 32'h8000_0000;
	localparam longint      LIM_HI = 64'sh0000_0000_7fff_ffff;
	localparam longint      LIM_LO = 64'shffff_ffff_8000_0000;

	// indexes past the register file; the block must drop writes to them
	localparam logic [bab_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [bab_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	typedef struct {
		logic [bab_pkg::CFG_IDX_W-1:0] idx;
		logic [bab_pkg::REG_W-1:0]     data;
	} reg_write_t;

	logic                          clk;
	logic                          arst_n;
	logic                          box_valid;
	logic                          box_stall;
	bab_pkg::box_t                 box;
	logic                          bounds_valid;
	logic                          bounds_stall;
	bab_pkg::bounds_t              bounds;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [bab_pkg::CFG_IDX_W-1:0] cfg_addr;
	logic [bab_pkg::REG_W-1:0]     cfg_data;

	// coefficient registers as this side believes them to be; follow every write seen
	logic [bab_pkg::REG_W-1:0] coef_regs [bab_pkg::NUM_REGS] = '{
		64'(Q_ONE), 64'd0, {Q_ONE, 32'd0}, 64'd0, 64'd0, 64'(Q_ONE)
	};
	bab_pkg::cfg_reg_t row_ab [bab_pkg::NUM_AXES] =
		'{bab_pkg::REG_ROW_X_AB, bab_pkg::REG_ROW_Y_AB, bab_pkg::REG_ROW_Z_AB};
	bab_pkg::cfg_reg_t row_cd [bab_pkg::NUM_AXES] =
		'{bab_pkg::REG_ROW_X_CD, bab_pkg::REG_ROW_Y_CD, bab_pkg::REG_ROW_Z_CD};

	bab_pkg::bounds_t pending_bounds [$];   // expected bounds, oldest request first
	reg_write_t       cfg_backlog [$];      // register writes staged for the next idle point

	int  error_count   = 0;
	int  result_count  = 0;
	int  quiet_cycles  = 0;
	int  src_idle_pct  = 0;
	int  sink_stall_pct = 0;
	int  hold_left     = 0;
	bit  hold_request  = 0;
	bit  offering      = 0;

	box_affine_bounds u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.box_valid    (box_valid),
		.box_stall    (box_stall),
		.box          (box),
		.bounds_valid (bounds_valid),
		.bounds_stall (bounds_stall),
		.bounds       (bounds),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_addr     (cfg_addr),
		.cfg_data     (cfg_data)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// ---------------------------------------------------------------------
	// Bounds prediction
	// ---------------------------------------------------------------------

	// Clamp a wide sum into 32 bits; bit 32 flags a clamp.
	function automatic logic [32:0] clamp_q(input longint v);
		if (v > LIM_HI)
			return {1'b1, Q_MAX};
		if (v < LIM_LO)
			return {1'b1, Q_MIN};
		return {1'b0, v[31:0]};
	endfunction

	// Per output axis, pick the smaller and larger product of each coefficient
	// over the two box coordinates; that equals min/max over the eight corners,
	// inverted boxes included. Products floor toward minus infinity.
	function automatic bab_pkg::bounds_t transform_bounds(input bab_pkg::box_t b);
		longint                    lo [3];
		longint                    hi [3];
		longint                    coef [3];
		longint                    p, q, sum_lo, sum_hi;
		logic [bab_pkg::REG_W-1:0] ab, cd;
		logic [32:0]               c_lo, c_hi;
		logic [31:0]               bnd_lo [3];
		logic [31:0]               bnd_hi [3];
		logic                      sat;
		bab_pkg::bounds_t          r;
		lo[0] = b.box_min_x;
		lo[1] = b.box_min_y;
		lo[2] = b.box_min_z;
		hi[0] = b.box_max_x;
		hi[1] = b.box_max_y;
		hi[2] = b.box_max_z;
		sat = 1'b0;
		for (int a = 0; a < bab_pkg::NUM_AXES; a++) begin
			ab = coef_regs[row_ab[a]];
			cd = coef_regs[row_cd[a]];
			coef[0] = longint'($signed(ab[31:0]));
			coef[1] = longint'($signed(ab[63:32]));
			coef[2] = longint'($signed(cd[31:0]));
			sum_lo = longint'($signed(cd[63:32]));
			sum_hi = sum_lo;
			for (int k = 0; k < 3; k++) begin
				p = (coef[k] * lo[k]) >>> FRAC;
				q = (coef[k] * hi[k]) >>> FRAC;
				if (p < q) begin
					sum_lo += p;
					sum_hi += q;
				end else begin
					sum_lo += q;
					sum_hi += p;
				end
			end
			c_lo = clamp_q(sum_lo);
			c_hi = clamp_q(sum_hi);
			sat = sat | c_lo[32] | c_hi[32];
			bnd_lo[a] = c_lo[31:0];
			bnd_hi[a] = c_hi[31:0];
		end
		r.out_min_x = bnd_lo[0];
		r.out_min_y = bnd_lo[1];
		r.out_min_z = bnd_lo[2];
		r.out_max_x = bnd_hi[0];
		r.out_max_y = bnd_hi[1];
		r.out_max_z = bnd_hi[2];
		r.saturated = sat;
		return r;
	endfunction

	// ---------------------------------------------------------------------
	// Checking
	// ---------------------------------------------------------------------

	task automatic report(input string msg);
		error_count++;
		if (error_count <= MAX_PRINTS)
			$display("[%0t] ERROR %s", $time, msg);
	endtask

	task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
		if (got !== want)
			report($sformatf("result %0d %s: got %h, want %h", result_count, name, got, want));
	endtask

	// Sample all three channels at the rising edge: track register writes,
	// predict on each accepted request, and check each accepted result.
	always @(posedge clk) begin
		bab_pkg::bounds_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready === 1'b1 && cfg_addr < bab_pkg::NUM_REGS)
				coef_regs[cfg_addr] = cfg_data;
			if (box_valid && box_stall === 1'b0)
				pending_bounds.push_back(transform_bounds(box));
			if (bounds_valid === 1'b1 && !bounds_stall) begin
				if (pending_bounds.size() == 0) begin
					report($sformatf("result %0d arrived with no request outstanding",
						result_count));
				end else begin
					want = pending_bounds.pop_front();
					check_field("out_min_x", bounds.out_min_x, want.out_min_x);
					check_field("out_min_y", bounds.out_min_y, want.out_min_y);
					check_field("out_min_z", bounds.out_min_z, want.out_min_z);
					check_field("out_max_x", bounds.out_max_x, want.out_max_x);
					check_field("out_max_y", bounds.out_max_y, want.out_max_y);
					check_field("out_max_z", bounds.out_max_z, want.out_max_z);
					check_field("saturated", 32'(bounds.saturated), 32'(want.saturated));
				end
				result_count++;
			end
		end
	end

	// Watchdog: end the run if no channel moves for too long.
	always @(posedge clk) begin
		if ((box_valid && box_stall === 1'b0) || (bounds_valid === 1'b1 && !bounds_stall)
				|| (cfg_valid && cfg_ready === 1'b1))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Receiver: stall at random, or hold off for a long stretch on request.
	always @(negedge clk) begin
		if (hold_request) begin
			hold_left = LONG_HOLD;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			bounds_stall <= 1'b1;
		end else begin
			bounds_stall <= ($urandom_range(99) < sink_stall_pct);
		end
	end

	// ---------------------------------------------------------------------
	// Driving
	// ---------------------------------------------------------------------

	// Offer one box; idle at random first, then hold it until accepted.
	task automatic send_box(input bab_pkg::box_t b);
		while ($urandom_range(99) < src_idle_pct) begin
			if (offering) begin
				box_valid <= 1'b0;
				offering = 0;
			end
			@(negedge clk);
		end
		box_valid <= 1'b1;
		box <= b;
		offering = 1;
		do @(posedge clk); while (box_stall !== 1'b0);
		@(negedge clk);
	endtask

	// Drop valid and wait until every request has come back.
	task automatic wait_drain();
		if (offering) begin
			box_valid <= 1'b0;
			offering = 0;
		end
		while (pending_bounds.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic stage_write(input logic [bab_pkg::CFG_IDX_W-1:0] idx,
			input logic [bab_pkg::REG_W-1:0] data);
		reg_write_t w;
		w.idx = idx;
		w.data = data;
		cfg_backlog.push_back(w);
	endtask

	task automatic stage_row(input int row, input logic [31:0] cx, input logic [31:0] cy,
			input logic [31:0] cz, input logic [31:0] trans);
		stage_write(row_ab[row], {cy, cx});
		stage_write(row_cd[row], {trans, cz});
	endtask

	// Write staged registers back to back once the block is idle.
	task automatic apply_config();
		reg_write_t w;
		wait_drain();
		while (cfg_backlog.size() != 0) begin
			w = cfg_backlog.pop_front();
			cfg_valid <= 1'b1;
			cfg_addr <= w.idx;
			cfg_data <= w.data;
			do @(posedge clk); while (cfg_ready !== 1'b1);
			@(negedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	function automatic bab_pkg::box_t mk_box(input logic [31:0] nx, input logic [31:0] ny,
			input logic [31:0] nz, input logic [31:0] xx, input logic [31:0] xy,
			input logic [31:0] xz);
		bab_pkg::box_t b;
		b.box_min_x = nx;
		b.box_min_y = ny;
		b.box_min_z = nz;
		b.box_max_x = xx;
		b.box_max_y = xy;
		b.box_max_z = xz;
		return b;
	endfunction

	// Mostly moderate coordinates, with extremes, near-zero and full-width values.
	function automatic logic [31:0] rand_coord();
		case ($urandom_range(9))
			0:       return $urandom();
			1:       return $urandom_range(1) ? Q_MAX : Q_MIN;
			2:       return $urandom_range(3) - 2;
			default: return $urandom_range(32'h01ff_ffff) - 32'h0100_0000;
		endcase
	endfunction

	// Mostly coefficients within +/-2.0 so most results stay in range.
	function automatic logic [31:0] rand_coef();
		case ($urandom_range(11))
			0:       return $urandom();
			1:       return Q_MAX;
			2:       return Q_MIN;
			3:       return 32'd0;
			4:       return Q_ONE;
			default: return $urandom_range(32'h0003_ffff) - 32'h0002_0000;
		endcase
	endfunction

	// Well-ordered boxes most of the time, inverted ones now and then.
	function automatic bab_pkg::box_t rand_box();
		logic [31:0] a [6];
		logic [31:0] t;
		foreach (a[i])
			a[i] = rand_coord();
		if ($urandom_range(99) < 85) begin
			for (int k = 0; k < 3; k++) begin
				if ($signed(a[k]) > $signed(a[k+3])) begin
					t = a[k];
					a[k] = a[k+3];
					a[k+3] = t;
				end
			end
		end
		return mk_box(a[0], a[1], a[2], a[3], a[4], a[5]);
	endfunction

	// ---------------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------------

	// Reset transform is the identity: bounds must equal the box, reordered where it is inverted.
	task automatic test_identity_edges();
		src_idle_pct = 0;
		sink_stall_pct = 0;
		send_box(mk_box(0, 0, 0, 0, 0, 0));
		send_box(mk_box(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX));
		send_box(mk_box(Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN));
		send_box(mk_box(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN));
		send_box(mk_box(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX));
		send_box(mk_box(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555,
			32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa));
	endtask

	// Writes past the last register must leave the transform untouched.
	task automatic test_spare_index();
		stage_write(REG_SPARE_LO, '1);
		stage_write(REG_SPARE_HI, {$urandom(), $urandom()});
		apply_config();
		send_box(mk_box(-32'sd1, 32'd2, Q_ONE, Q_ONE, -32'sd5, 32'd7));
	endtask

	// Largest and smallest coefficients and translations: clamp at both ends.
	task automatic test_saturation();
		for (int r = 0; r < bab_pkg::NUM_AXES; r++)
			stage_row(r, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
		apply_config();
		send_box(mk_box(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX));
		send_box(mk_box(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN));
		send_box(mk_box(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX));
		for (int r = 0; r < bab_pkg::NUM_AXES; r++)
			stage_row(r, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
		apply_config();
		send_box(mk_box(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX));
		send_box(mk_box(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN));
		send_box(mk_box(Q_MIN, 0, Q_MAX, Q_MAX, 0, Q_MIN));
	endtask

	// Tiny coefficients expose the floor on negative products; translation at
	// the top of the range tips one bound over; then a flip with inverted boxes.
	task automatic test_floor_and_flip();
		stage_row(0, 32'd1, 32'd0, 32'd0, 32'd0);
		stage_row(1, 32'd0, -32'sd1, 32'd0, 32'd0);
		stage_row(2, 32'd0, 32'd0, Q_ONE, Q_MAX);
		apply_config();
		send_box(mk_box(-32'sd1, -32'sd1, 32'd0, 32'd1, 32'd1, 32'd1));
		send_box(mk_box(-32'sd65537, 32'd65535, -32'sd1, -32'sd65536, 32'd65537, 32'd0));
		stage_row(0, 32'd0, -Q_ONE, 32'd0, 32'h0001_8000);
		stage_row(1, Q_ONE, 32'd0, 32'd0, Q_MIN);
		stage_row(2, 32'd0, 32'd0, -Q_ONE, 32'd0);
		apply_config();
		send_box(mk_box(32'd3, 32'd10, 32'd4, -32'sd3, -32'sd10, -32'sd4));
		send_box(mk_box(-32'sd1, Q_MIN, Q_MIN, 32'd1, Q_MAX, Q_MAX));
		send_box(mk_box(Q_MAX, 32'd0, 32'd0, Q_MIN, 32'd0, 32'd0));
	endtask

	// Hold the receiver off while the sender keeps offering, so the pipeline
	// fills and box_stall rises, then let it all drain.
	task automatic test_backpressure();
		apply_config();
		src_idle_pct = 0;
		sink_stall_pct = 0;
		hold_request = 1;
		repeat (60)
			send_box(rand_box());
		wait_drain();
	endtask

	// Pause the sender until every result is back, then resume.
	task automatic test_sender_pause();
		src_idle_pct = 24;
		sink_stall_pct = 24;
		repeat (20)
			send_box(rand_box());
		wait_drain();
		repeat (20)
			send_box(rand_box());
	endtask

	// Random boxes under a fresh random transform per batch, at one idling mix.
	task automatic test_random_phase(input int src_pct, input int sink_pct, input int n);
		for (int batch = 0; batch < 2; batch++) begin
			for (int r = 0; r < bab_pkg::NUM_AXES; r++)
				stage_row(r, rand_coef(), rand_coef(), rand_coef(), rand_coord());
			if ($urandom_range(1))
				stage_write($urandom_range(1) ? REG_SPARE_LO : REG_SPARE_HI,
					{$urandom(), $urandom()});
			apply_config();
			src_idle_pct = src_pct;
			sink_stall_pct = sink_pct;
			repeat (n / 2)
				send_box(rand_box());
		end
	endtask

	// ---------------------------------------------------------------------
	// Sequence
	// ---------------------------------------------------------------------

	initial begin
		arst_n = 1'b0;
		box_valid = 1'b0;
		box = '0;
		bounds_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_addr = '0;
		cfg_data = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_identity_edges();
		test_spare_index();
		test_saturation();
		test_floor_and_flip();
		test_backpressure();
		test_sender_pause();
		test_random_phase(0, 0, 270);
		test_random_phase(52, 0, 270);
		test_random_phase(0, 52, 270);
		test_random_phase(24, 24, 270);

		// drain, then give any stray result time to show up
		wait_drain();
		repeat (TAIL_WAIT) @(posedge clk);
		if (error_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

FILE: sim.f
design/bab_pkg.sv
design/bab_row.sv
design/box_affine_bounds.sv
design/bab_checker.sv
test/tb.sv
